@@ rtl/sparse_dense_score_accumulator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Score accumulator assertion macros
// Short forms for the concurrent checks of the score accumulator.
// ----------------------------------------------------------------------------
`ifndef SPARSE_DENSE_SCORE_ACCUMULATOR_UNIT_ASSERT_SVH
`define SPARSE_DENSE_SCORE_ACCUMULATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SDSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sdsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Score accumulator package
// Types, constants and arithmetic helpers shared by the accumulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsa_pkg;

	// matrix geometry
	localparam int SCORES   = 8;
	localparam int SAMPLES  = 1024;
	localparam int DEPTH    = SCORES * SAMPLES;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SCORE_AW = (SCORES > 1) ? $clog2(SCORES) : 1;

	// arithmetic widths
	localparam int BETA_W = 32;
	localparam int DOSE_W = 17;
	localparam int PROD_W = BETA_W + DOSE_W;
	localparam int ACC_W  = 64;

	// command codes
	localparam logic [2:0] CMD_DENSE     = 3'd0;
	localparam logic [2:0] CMD_SPARSE    = 3'd1;
	localparam logic [2:0] CMD_BASELINE  = 3'd2;
	localparam logic [2:0] CMD_INTERCEPT = 3'd3;
	localparam logic [2:0] CMD_FINALIZE  = 3'd4;

	localparam logic [15:0] MISSING_CODE = 16'hFFFF;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [2:0]         score_index;
		logic [9:0]         sample_index;
		logic signed [31:0] beta;
		logic [15:0]        dosage_code;
		logic [15:0]        common_dosage;
		logic [15:0]        mean_dosage;
		logic signed [63:0] intercept;
	} req_t;

	typedef struct packed {
		logic [2:0]         out_score_index;
		logic [9:0]         out_sample_index;
		logic signed [63:0] final_score;
	} rsp_t;

	// multiplier operand picked by command
	function automatic logic signed [DOSE_W-1:0] dose_sel(
		input logic [2:0]  cmd,
		input logic [15:0] code,
		input logic [15:0] common,
		input logic [15:0] mean
	);
		logic [15:0] d;
		logic signed [DOSE_W-1:0] r;
		d = (code == MISSING_CODE) ? mean : code;
		case (cmd)
			CMD_DENSE:    r = signed'({1'b0, code});
			CMD_SPARSE:   r = signed'({1'b0, d}) - signed'({1'b0, common});
			CMD_BASELINE: r = signed'({1'b0, common});
			default:      r = '0;
		endcase
		return r;
	endfunction

	// signed add clamped to the accumulator range
	function automatic logic [ACC_W-1:0] sat_add(
		input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b
	);
		logic [ACC_W-1:0] s;
		s = a + b;
		if (!(a[ACC_W-1] ^ b[ACC_W-1]) && (a[ACC_W-1] ^ s[ACC_W-1]))
			return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		return s;
	endfunction

endpackage

@@ rtl/sdsa_ram.sv @@
// ----------------------------------------------------------------------------
// Score accumulator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsa_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sdsa_weigh.sv @@
// ----------------------------------------------------------------------------
// Score accumulator weight multiplier
// Registered signed product of weight and dosage term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsa_weigh import sdsa_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [BETA_W-1:0] beta,
	input  logic signed [DOSE_W-1:0] dose,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_s2;

	// exact product, held while the pipeline stalls
	always_ff @(posedge clk) begin
		if (en)
			prod_s2 <= PROD_W'(beta) * PROD_W'(dose);
	end

	assign prod = prod_s2;

endmodule

@@ rtl/sparse_dense_score_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// Sparse/dense score accumulator
// Saturating fixed-point accumulation of weighted dosages into a score matrix
// held in RAM, with a per-score baseline and a finalize that emits entries.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid, req_stall | req_t (command and operands)
//  rsp      | out       | rsp_valid, rsp_stall | rsp_t (finalized entry)
//
//  one transaction per cycle sustained while req_stall is low; a finalize result
//  passes operand select, multiply with RAM read, then add with write back
//  after reset every entry of the matrix RAM is swept to zero (one entry per
//  cycle through its single write port); req_stall is high meanwhile
//  a finalize blocked by a full, stalled output register holds the pipeline
//  back-to-back updates of one entry are served by forwarding the last write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_dense_score_accumulator_unit import sdsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	`include "sparse_dense_score_accumulator_unit_assert.svh"

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;

	// stage 1 registers
	logic                     s1_valid_q;
	logic [2:0]               cmd_s1;
	logic [2:0]               score_s1;
	logic [9:0]               sample_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic signed [BETA_W-1:0] beta_s1;
	logic signed [DOSE_W-1:0] dose_s1;
	logic [ACC_W-1:0]         icpt_s1;

	// stage 2 registers
	logic              s2_valid_q;
	logic [2:0]        cmd_s2;
	logic [2:0]        score_s2;
	logic [9:0]        sample_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [ACC_W-1:0]  icpt_s2;
	logic              bypass_s2;
	logic [ACC_W-1:0]  last_wdata_q;

	logic [ACC_W-1:0] baseline_q [SCORES];

	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic                     accept;
	logic                     item_ok;
	logic                     move;
	logic                     s2_done;
	logic                     s2_emit;
	logic                     s2_matrix;
	logic                     s2_base;
	logic                     slot_free;
	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0]         mem_rdata;
	logic [ACC_W-1:0]         entry_cur;
	logic [ACC_W-1:0]         base_cur;
	logic [ACC_W-1:0]         op_a;
	logic [ACC_W-1:0]         op_b;
	logic [ACC_W-1:0]         sum;
	logic                     mem_we;
	logic                     run_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [ACC_W-1:0]         mem_wdata;

	// clear sweep state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(DEPTH - 1))
					state_d = ST_RUN;
			end
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// pipeline flow control
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign s2_emit   = (cmd_s2 == CMD_FINALIZE);
	assign s2_matrix = (cmd_s2 == CMD_DENSE) || (cmd_s2 == CMD_SPARSE) || s2_emit;
	assign s2_base   = (cmd_s2 == CMD_BASELINE) || (cmd_s2 == CMD_INTERCEPT);
	assign s2_done   = s2_valid_q && (!s2_emit || slot_free);
	assign move      = !s2_valid_q || s2_done;
	assign req_stall = (state_q == ST_CLEAR) || !move;
	assign accept    = req_valid && !req_stall;

	// commands out of range or unused are taken and dropped
	always_comb begin
		item_ok = (req.command <= CMD_FINALIZE) && (32'(req.score_index) < SCORES);
		if ((req.command != CMD_BASELINE) && (req.command != CMD_INTERCEPT))
			item_ok = item_ok && (32'(req.sample_index) < SAMPLES);
	end

	// stage 1: operand select and address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (move)
			s1_valid_q <= accept && item_ok;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.command;
			score_s1  <= req.score_index;
			sample_s1 <= req.sample_index;
			addr_s1   <= ADDR_W'(req.score_index) * ADDR_W'(SAMPLES)
				+ ADDR_W'(req.sample_index);
			beta_s1   <= req.beta;
			dose_s1   <= dose_sel(req.command, req.dosage_code, req.common_dosage,
				req.mean_dosage);
			icpt_s1   <= req.intercept;
		end
	end

	sdsa_weigh u_weigh (
		.clk  (clk),
		.en   (move),
		.beta (beta_s1),
		.dose (dose_s1),
		.prod (prod)
	);

	// stage 2 registers and forwarding of the write that races the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (move)
			s2_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			cmd_s2       <= cmd_s1;
			score_s2     <= score_s1;
			sample_s2    <= sample_s1;
			addr_s2      <= addr_s1;
			icpt_s2      <= icpt_s1;
			bypass_s2    <= run_we && (addr_s2 == addr_s1);
			last_wdata_q <= sum;
		end
	end

	// matrix memory: clear sweep or write back share the write port
	assign run_we    = s2_done && s2_matrix;
	assign mem_we    = (state_q == ST_CLEAR) || run_we;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_s2;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : sum;

	sdsa_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ACC_W),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (move && s1_valid_q),
		.raddr (addr_s1),
		.rdata (mem_rdata)
	);

	// stage 2: saturating add
	assign entry_cur = bypass_s2 ? last_wdata_q : mem_rdata;
	assign base_cur  = baseline_q[SCORE_AW'(score_s2)];

	always_comb begin
		case (cmd_s2)
			CMD_DENSE, CMD_SPARSE: begin
				op_a = entry_cur;
				op_b = ACC_W'(prod);
			end
			CMD_BASELINE: begin
				op_a = base_cur;
				op_b = ACC_W'(prod);
			end
			CMD_INTERCEPT: begin
				op_a = icpt_s2;
				op_b = '0;
			end
			CMD_FINALIZE: begin
				op_a = entry_cur;
				op_b = base_cur;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		sum = sat_add(op_a, op_b);
	end

	// baseline store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCORES; i++)
				baseline_q[i] <= '0;
		end else if (s2_done && s2_base) begin
			baseline_q[SCORE_AW'(score_s2)] <= sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (s2_done && s2_emit)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_done && s2_emit) begin
			rsp_q.out_score_index  <= score_s2;
			rsp_q.out_sample_index <= sample_s2;
			rsp_q.final_score      <= sum;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`SDSA_ASSERT_SAME(a_clear_empty, clk, arst_n, state_q == ST_CLEAR,
		!s1_valid_q && !s2_valid_q, "pipeline busy during clear sweep")
	`SDSA_ASSERT_SAME(a_blocked_no_write, clk, arst_n, s2_valid_q && !s2_done,
		!run_we, "write back from a blocked stage")
	`SDSA_ASSERT_NEXT(a_finalize_emits, clk, arst_n, s2_done && s2_emit,
		rsp_valid, "finalize without result")

endmodule
